// ===== hdl/i2ds_pkg.sv =====
// Shared constants and types of the integer to decimal string converter.
// Used by the channel interfaces, every RTL module and the checker.
`default_nettype none

package i2ds_pkg;

  // Width of the two's complement input value.
  localparam int VALUE_BITS = 32;
  // Decimal digits needed for the largest magnitude, 2**(VALUE_BITS-1).
  // 1233 / 4096 is a close lower bound on log10(2).
  localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  // Width of the internal string length (sign plus digits).
  localparam int LEN_BITS = $clog2(DIGITS + 2);
  localparam int DIDX_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int STEP_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  localparam int CAP_BITS = 8;
  localparam int CH_BITS = 7;
  localparam int LENGTH_BITS = 4;

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [CH_BITS-1:0] CH_NUL = 7'h00;
  localparam logic [CH_BITS-1:0] CH_MINUS = 7'h2D;
  localparam logic [CH_BITS-1:0] CH_ZERO = 7'h30;

  // One classified conversion job handed from the front to the back.
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic neg;
    logic [CAP_BITS-1:0] cap;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/i2ds_num_if.sv =====
// Channel interface that carries one input value and its buffer capacity.
// Depends on i2ds_pkg for the field widths.
`default_nettype none

interface i2ds_num_if;
  logic valid;
  logic ready;
  logic signed [i2ds_pkg::VALUE_BITS-1:0] value;
  logic [i2ds_pkg::CAP_BITS-1:0] capacity;

  modport source (output valid, value, capacity, input ready);
  modport sink (input valid, value, capacity, output ready);
endinterface

`default_nettype wire

// ===== hdl/i2ds_text_if.sv =====
// Channel interface that carries one character of the decimal string.
// Depends on i2ds_pkg for the field widths.
`default_nettype none

interface i2ds_text_if;
  logic valid;
  logic ready;
  logic [i2ds_pkg::CH_BITS-1:0] ch;
  logic last;
  logic fits;
  logic [i2ds_pkg::LENGTH_BITS-1:0] length;

  modport source (output valid, ch, last, fits, length, input ready);
  modport sink (input valid, ch, last, fits, length, output ready);
endinterface

`default_nettype wire

// ===== hdl/i2ds_front.sv =====
// Front part: accepts input values, splits sign and magnitude, and queues jobs.
// Depends on i2ds_pkg and i2ds_num_if.
`default_nettype none

module i2ds_front (
  input  wire logic clk,
  input  wire logic rst,
  i2ds_num_if.sink number,
  output i2ds_pkg::job_t job,
  output logic job_valid,
  input  wire logic job_ready
);

  i2ds_pkg::job_t queue [i2ds_pkg::QUEUE_DEPTH];
  logic [i2ds_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [i2ds_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [i2ds_pkg::QPTR_BITS:0] count;
  logic [i2ds_pkg::VALUE_BITS-1:0] raw;
  logic push;
  logic pop;
  i2ds_pkg::job_t classified;

  assign raw = number.value;

  always_comb begin
    classified.neg = raw[i2ds_pkg::VALUE_BITS-1];
    // Unsigned negate, so the most negative value keeps its full magnitude.
    classified.mag = classified.neg ? (~raw + 1'b1) : raw;
    classified.cap = number.capacity;
  end

  assign number.ready = (count != (i2ds_pkg::QPTR_BITS + 1)'(i2ds_pkg::QUEUE_DEPTH));
  assign job_valid = (count != '0);
  assign job = queue[rd_ptr];
  assign push = number.valid && number.ready;
  assign pop = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classified;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2ds_back.sv =====
// Back part: binary to BCD by shift-add-3, length check, and character emission.
// Depends on i2ds_pkg and i2ds_text_if.
`default_nettype none

module i2ds_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire i2ds_pkg::job_t job,
  input  wire logic job_valid,
  output logic job_ready,
  i2ds_text_if.source text
);

  typedef enum logic [2:0] {
    IDLE,
    CONV,
    SIZE,
    SIGN,
    DIGIT,
    TERM
  } state_t;

  state_t state;
  logic [i2ds_pkg::VALUE_BITS-1:0] shifter;
  logic [i2ds_pkg::DIGITS*4-1:0] bcd;
  logic [i2ds_pkg::DIGITS*4-1:0] bcd_adj;
  logic [i2ds_pkg::STEP_BITS-1:0] step;
  logic neg;
  logic [i2ds_pkg::CAP_BITS-1:0] cap;
  logic [i2ds_pkg::LEN_BITS-1:0] len;
  logic [i2ds_pkg::LEN_BITS-1:0] len_next;
  logic [i2ds_pkg::LEN_BITS-1:0] ndig;
  logic fits;
  logic fits_next;
  logic [i2ds_pkg::DIDX_BITS-1:0] dptr;
  logic [3:0] cur_digit;
  logic slot_free;
  logic emit;

  assign job_ready = (state == IDLE);
  assign slot_free = !text.valid || text.ready;
  // A new character is loaded into the output register this cycle.
  assign emit = slot_free && (state inside {SIGN, DIGIT, TERM});
  assign cur_digit = bcd[dptr*4 +: 4];

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < i2ds_pkg::DIGITS; i++) begin
      d = bcd[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
    end
  end

  // Digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    ndig = (i2ds_pkg::LEN_BITS)'(1);
    for (int i = 0; i < i2ds_pkg::DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        ndig = (i2ds_pkg::LEN_BITS)'(i + 1);
      end
    end
    len_next = ndig + (i2ds_pkg::LEN_BITS)'(neg);
    fits_next = (cap > (i2ds_pkg::CAP_BITS)'(len_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      text.valid <= 1'b0;
    end else begin
      if (text.valid && text.ready && !emit) begin
        text.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (job_valid) begin
            shifter <= job.mag;
            neg <= job.neg;
            cap <= job.cap;
            bcd <= '0;
            step <= '0;
            state <= CONV;
          end
        end
        CONV: begin
          bcd <= {bcd_adj[i2ds_pkg::DIGITS*4-2:0], shifter[i2ds_pkg::VALUE_BITS-1]};
          shifter <= shifter << 1;
          step <= step + 1'b1;
          if (step == (i2ds_pkg::STEP_BITS)'(i2ds_pkg::VALUE_BITS - 1)) begin
            state <= SIZE;
          end
        end
        SIZE: begin
          len <= len_next;
          fits <= fits_next;
          dptr <= (i2ds_pkg::DIDX_BITS)'(ndig - 1'b1);
          if (!fits_next) begin
            state <= TERM;
          end else if (neg) begin
            state <= SIGN;
          end else begin
            state <= DIGIT;
          end
        end
        SIGN: begin
          if (slot_free) begin
            text.valid <= 1'b1;
            text.ch <= i2ds_pkg::CH_MINUS;
            text.last <= 1'b0;
            text.fits <= 1'b1;
            text.length <= '0;
            state <= DIGIT;
          end
        end
        DIGIT: begin
          if (slot_free) begin
            text.valid <= 1'b1;
            text.ch <= i2ds_pkg::CH_ZERO + (i2ds_pkg::CH_BITS)'(cur_digit);
            text.last <= 1'b0;
            text.fits <= 1'b1;
            text.length <= '0;
            if (dptr == '0) begin
              state <= TERM;
            end else begin
              dptr <= dptr - 1'b1;
            end
          end
        end
        TERM: begin
          if (slot_free) begin
            text.valid <= 1'b1;
            text.ch <= i2ds_pkg::CH_NUL;
            text.last <= 1'b1;
            text.fits <= fits;
            text.length <= fits ? (i2ds_pkg::LENGTH_BITS)'(len) : '0;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/int_to_decimal_string.sv =====
// Top level of the signed integer to decimal ASCII string converter.
// Depends on i2ds_pkg, i2ds_num_if, i2ds_text_if, i2ds_front and i2ds_back.
//
// Each transaction on the number channel carries a two's complement value and
// the capacity of the destination buffer, counted with its terminating NUL.
// The block answers with one transaction per character on the text channel:
// an optional '-', the decimal digits most significant first, and a NUL whose
// transaction has last set and carries the string length without the NUL.
// When the buffer is too small for string and NUL, a single transaction with
// a NUL character, last set, fits clear and length zero is sent instead.
// The front part classifies the value into sign and magnitude and holds up to
// two jobs in a small queue, so new values are taken while a conversion runs.
// The back part converts one job at a time: it loads the job, runs one
// shift-add-3 step per value bit, sizes the string, then sends the
// characters one by one, the NUL included, and waits while the output
// register holds a character not yet taken. Characters leave through that
// register, so once the NUL is loaded the back part takes and converts the
// next job while the NUL waits to be taken. Nothing is kept from one
// value to the next.
`default_nettype none

module int_to_decimal_string (
  input  wire logic clk,
  input  wire logic rst,
  i2ds_num_if.sink number,
  i2ds_text_if.source text
);

  i2ds_pkg::job_t job;
  logic job_valid;
  logic job_ready;

  // Sign and magnitude split plus the job queue.
  i2ds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .number    (number),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  // BCD conversion, size check and character output.
  i2ds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .text      (text)
  );

endmodule

`default_nettype wire

// ===== hdl/i2ds_checker.sv =====
// Port level checker for the converter's text channel, with its bind statement.
// Depends on i2ds_pkg and on the ports of int_to_decimal_string.
`default_nettype none

module i2ds_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  input wire logic ready,
  input wire logic [i2ds_pkg::CH_BITS-1:0] ch,
  input wire logic last,
  input wire logic fits,
  input wire logic [i2ds_pkg::LENGTH_BITS-1:0] length
);

  // A stalled character stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable({ch, last, fits, length}))
    else $error("text transaction changed while stalled");

  // A string that does not fit is reported by one bare terminating NUL.
  a_no_fit: assert property (@(posedge clk) disable iff (rst)
    valid && !fits |-> last && (ch == i2ds_pkg::CH_NUL) && (length == '0))
    else $error("overflow report is malformed");

  // Characters before the end are visible and carry no length.
  a_body: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> fits && (length == '0) && (ch != i2ds_pkg::CH_NUL))
    else $error("string body transaction is malformed");

  // The final transaction is always the NUL terminator.
  a_term: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> (ch == i2ds_pkg::CH_NUL))
    else $error("last transaction is not the terminator");

endmodule

bind int_to_decimal_string i2ds_checker u_i2ds_checker (
  .clk    (clk),
  .rst    (rst),
  .valid  (text.valid),
  .ready  (text.ready),
  .ch     (text.ch),
  .last   (text.last),
  .fits   (text.fits),
  .length (text.length)
);

`default_nettype wire

// ===== verif/i2ds_string_check.sv =====
`timescale 1ns / 1ps
// Checker for the integer to decimal string converter: predicts each value's characters.
// Depends on i2ds_pkg, i2ds_num_if and i2ds_text_if. Reports a mismatch count to the test top.

module i2ds_string_check (
  input  logic clk,
  input  logic rst,
  i2ds_num_if number,
  i2ds_text_if text,
  output int errors,
  output int pending
);

  typedef struct packed {
    logic [i2ds_pkg::CH_BITS-1:0] ch;
    logic last;
    logic fits;
    logic [i2ds_pkg::LENGTH_BITS-1:0] length;
  } text_item_t;

  // Characters still owed by the block, oldest first.
  text_item_t text_due[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: text mismatch: %s", $time, what);
    errors++;
  endtask

  // Turns one value and buffer capacity into the characters the block must send.
  task automatic queue_decimal_text(input logic [i2ds_pkg::VALUE_BITS-1:0] raw,
                                    input logic [i2ds_pkg::CAP_BITS-1:0] cap);
    logic negative;
    logic [i2ds_pkg::VALUE_BITS-1:0] mag;
    logic [3:0] digit_buf [i2ds_pkg::DIGITS];
    int ndig;
    int slen;
    negative = raw[i2ds_pkg::VALUE_BITS-1];
    // Unsigned magnitude, so the most negative value stays exact.
    mag = negative ? (~raw + 1'b1) : raw;
    ndig = 0;
    do begin
      digit_buf[ndig] = 4'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0);
    slen = ndig + (negative ? 1 : 0);
    if (int'(cap) < slen + 1) begin
      text_due.push_back('{ch: i2ds_pkg::CH_NUL, last: 1'b1, fits: 1'b0, length: '0});
    end else begin
      if (negative) begin
        text_due.push_back('{ch: i2ds_pkg::CH_MINUS, last: 1'b0, fits: 1'b1, length: '0});
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        text_due.push_back('{ch: i2ds_pkg::CH_ZERO + (i2ds_pkg::CH_BITS)'(digit_buf[i]),
                             last: 1'b0, fits: 1'b1, length: '0});
      end
      text_due.push_back('{ch: i2ds_pkg::CH_NUL, last: 1'b1, fits: 1'b1,
                           length: (i2ds_pkg::LENGTH_BITS)'(slen)});
    end
  endtask

  always @(posedge clk) begin
    text_item_t want;
    if (!rst) begin
      if (number.valid && number.ready) begin
        queue_decimal_text(number.value, number.capacity);
      end
      if (text.valid && text.ready) begin
        if (text_due.size() == 0) begin
          report_mismatch($sformatf("character %0h with nothing pending", text.ch));
        end else begin
          want = text_due.pop_front();
          if (text.ch !== want.ch) begin
            report_mismatch($sformatf("ch got %0h want %0h", text.ch, want.ch));
          end
          if (text.last !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b", text.last, want.last));
          end
          if (text.fits !== want.fits) begin
            report_mismatch($sformatf("fits got %0b want %0b", text.fits, want.fits));
          end
          if (text.length !== want.length) begin
            report_mismatch($sformatf("length got %0d want %0d", text.length, want.length));
          end
        end
      end
      pending = text_due.size();
    end
  end

endmodule

// ===== verif/int_to_decimal_string_test.sv =====
`timescale 1ns / 1ps
// Test top for the integer to decimal string converter: clock, reset, stimulus and verdict.
// Depends on i2ds_pkg, both channel interfaces, int_to_decimal_string and i2ds_string_check.

module int_to_decimal_string_test;

  // A correct block never goes this long without a transaction on either channel.
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 140;
  // Cycles allowed after the last character, a little over one back-end job.
  localparam int TAIL_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int errors;
  int pending;

  i2ds_num_if number_bus ();
  i2ds_text_if text_bus ();

  int_to_decimal_string dut (
    .clk(clk),
    .rst(rst),
    .number(number_bus),
    .text(text_bus)
  );

  i2ds_string_check string_check (
    .clk(clk),
    .rst(rst),
    .number(number_bus),
    .text(text_bus),
    .errors(errors),
    .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Each side alternates between runs of random idling and runs with none at all,
  // so that both back-to-back traffic and gaps at every stage of a conversion occur.
  int send_run = 0;
  bit send_calm = 1'b0;
  int take_run = 0;
  bit take_calm = 1'b0;

  // Sends one value on the number channel. Called and returns at a falling edge.
  // When no gap is drawn, valid simply stays high for the next transaction.
  task automatic send_number(input logic [i2ds_pkg::VALUE_BITS-1:0] v,
                             input logic [i2ds_pkg::CAP_BITS-1:0] cap);
    int gap;
    if (send_run == 0) begin
      send_run = $urandom_range(3, 20);
      send_calm = ($urandom_range(0, 2) == 0);
    end
    send_run--;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      number_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    number_bus.valid <= 1'b1;
    number_bus.value <= v;
    number_bus.capacity <= cap;
    do @(posedge clk); while (!number_bus.ready);
    @(negedge clk);
  endtask

  // Random values lean toward the interesting places: powers of ten where the
  // digit count changes, the two ends of the range, and short strings.
  function automatic logic [i2ds_pkg::VALUE_BITS-1:0] pick_value();
    logic [i2ds_pkg::VALUE_BITS-1:0] v;
    logic [i2ds_pkg::VALUE_BITS-1:0] p;
    int k;
    case ($urandom_range(0, 5))
      0: begin
        v = (i2ds_pkg::VALUE_BITS)'($urandom_range(0, 20)) - 10;
      end
      1: begin
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      end
      2: begin
        if ($urandom_range(0, 1) == 1) v = 32'h8000_0000 + $urandom_range(0, 3);
        else v = 32'h7fff_ffff - $urandom_range(0, 3);
      end
      3: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  // Half the capacities sit where strings of one to eleven characters stop fitting;
  // the rest are roomy or anywhere in the full range.
  function automatic logic [i2ds_pkg::CAP_BITS-1:0] pick_capacity();
    case ($urandom_range(0, 3))
      0, 1: return (i2ds_pkg::CAP_BITS)'($urandom_range(0, 13));
      2: return (i2ds_pkg::CAP_BITS)'($urandom_range(12, 255));
      default: return (i2ds_pkg::CAP_BITS)'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: draws a stall before every character, then holds ready until one is taken.
  initial begin
    int stall;
    text_bus.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (take_run == 0) begin
        take_run = $urandom_range(3, 30);
        take_calm = ($urandom_range(0, 2) == 0);
      end
      take_run--;
      stall = take_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        text_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      text_bus.ready <= 1'b1;
      do @(posedge clk); while (!text_bus.valid);
      @(negedge clk);
    end
  end

  // Watchdog: a run of cycles with no transaction at all means the block has hung.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst == 1'b0);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((number_bus.valid && number_bus.ready) || (text_bus.valid && text_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no transaction for %0d cycles, %0d characters pending",
             IDLE_LIMIT, pending);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    number_bus.valid = 1'b0;
    number_bus.value = '0;
    number_bus.capacity = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Zero, single digits and sign changes first, then the two
    // ends of the range with the buffer exactly large enough and one short,
    // then zero and full capacity, and digit-count boundaries.
    send_number(32'd0, 8'd1);
    send_number(32'd0, 8'd0);
    send_number(32'd7, 8'd255);
    send_number(-32'sd1, 8'd3);
    send_number(-32'sd1, 8'd2);
    send_number(32'd9, 8'd2);
    send_number(32'd10, 8'd3);
    send_number(-32'sd10, 8'd3);
    send_number(32'h7fff_ffff, 8'd11);
    send_number(32'h7fff_ffff, 8'd10);
    send_number(32'h8000_0000, 8'd12);
    send_number(32'h8000_0000, 8'd11);
    send_number(32'h8000_0001, 8'd255);
    send_number(32'd1_000_000_000, 8'd11);
    send_number(-32'sd1_000_000_000, 8'd12);
    send_number(32'd999_999_999, 8'd10);
    send_number(32'd123_456_789, 8'd9);
    send_number(-32'sd5, 8'd128);
    send_number(32'd42, 8'd0);
    send_number(32'hffff_fff6, 8'd64);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_number(pick_value(), pick_capacity());
    end
    number_bus.valid <= 1'b0;

    // Drain: every owed character must arrive, then nothing more may follow.
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== int_to_decimal_string.f =====
hdl/i2ds_pkg.sv
hdl/i2ds_num_if.sv
hdl/i2ds_text_if.sv
hdl/i2ds_front.sv
hdl/i2ds_back.sv
hdl/int_to_decimal_string.sv
hdl/i2ds_checker.sv
verif/i2ds_string_check.sv
verif/int_to_decimal_string_test.sv
